### design/skat_pkg.sv
// shared types and constants of the slot key allocator table
// no dependencies

package skat_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 7;
    localparam int HALF_W   = 16;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_DELETE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  req_key;
        logic [HALF_W-1:0] file_ident;
        logic [HALF_W-1:0] line_row;
        logic [HALF_W-1:0] line_col;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  out_key;
        logic [HALF_W-1:0] out_file_ident;
        logic [HALF_W-1:0] out_row;
        logic [HALF_W-1:0] out_col;
    } t_res;

    typedef struct packed {
        logic [HALF_W-1:0] file_ident;
        logic [HALF_W-1:0] line_row;
        logic [HALF_W-1:0] line_col;
    } t_payload;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

### design/skat_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module skat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/skat_ctrl.sv
// controller state machine: accept, then execute one operation
// depends on skat_pkg

module skat_ctrl import skat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_start;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                o_busy        = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

### design/skat_dp.sv
// datapath: payload and free-key rams, occupancy bits, counters, result register
// depends on skat_pkg and skat_ram

module skat_dp import skat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);

    t_req                r_req;
    logic [CAPACITY-1:0] r_occ;
    logic [CAPACITY-1:0] n_occ;
    logic [CNT_W-1:0]    r_fsc;
    logic [CNT_W-1:0]    n_fsc;
    logic [CNT_W-1:0]    r_hwm;
    logic [CNT_W-1:0]    n_hwm;
    logic                r_valid;
    t_res                r_res;
    t_res                n_res;

    t_payload            pl_rdata;
    logic                pl_we;
    logic [ADDR_W-1:0]   pl_waddr;
    logic [KEY_W-1:0]    stk_rdata;
    logic                stk_we;
    logic [ADDR_W-1:0]   stk_waddr;

    logic [KEY_W-1:0]    in_key_m1;
    logic [CNT_W-1:0]    fsc_m1;
    logic [KEY_W-1:0]    key_m1;
    logic [KEY_W-1:0]    new_key;
    logic [KEY_W-1:0]    new_key_m1;
    logic                key_ok;

    // the payload read address comes straight from the request word at accept
    assign in_key_m1 = i_req.req_key - KEY_W'(1);
    assign fsc_m1    = r_fsc - CNT_W'(1);

    skat_ram #(
        .WIDTH ($bits(t_payload)),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata ({r_req.file_ident, r_req.line_row, r_req.line_col}),
        .i_re    (i_cmd.capture),
        .i_raddr (in_key_m1[ADDR_W-1:0]),
        .o_rdata (pl_rdata)
    );

    skat_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_req.req_key),
        .i_re    (i_cmd.capture),
        .i_raddr (fsc_m1[ADDR_W-1:0]),
        .o_rdata (stk_rdata)
    );

    assign key_m1 = r_req.req_key - KEY_W'(1);
    assign key_ok = (r_req.req_key != '0)
                 && ({1'b0, r_req.req_key} <= {1'b0, KEY_W'(r_hwm)})
                 && (r_req.req_key <= KEY_W'(CAPACITY))
                 && r_occ[key_m1[ADDR_W-1:0]];

    always_comb begin
        n_occ      = r_occ;
        n_fsc      = r_fsc;
        n_hwm      = r_hwm;
        n_res      = '0;
        pl_we      = 1'b0;
        pl_waddr   = '0;
        stk_we     = 1'b0;
        stk_waddr  = r_fsc[ADDR_W-1:0];
        new_key    = '0;
        new_key_m1 = '0;
        n_res.out_key = r_req.req_key;
        n_res.status  = ST_MISSING;
        case (r_req.func)
            FUNC_PUSH: begin
                if (r_fsc != '0 && r_fsc <= CNT_W'(CAPACITY)) begin
                    n_fsc   = fsc_m1;
                    new_key = stk_rdata;
                end else if (r_hwm < CNT_W'(CAPACITY)) begin
                    n_hwm   = r_hwm + CNT_W'(1);
                    new_key = KEY_W'(n_hwm);
                end
                new_key_m1 = new_key - KEY_W'(1);
                if (new_key == '0) begin
                    n_res.status  = ST_FULL;
                    n_res.out_key = '0;
                end else begin
                    n_res.status  = ST_OK;
                    n_res.out_key = new_key;
                    if (new_key <= KEY_W'(CAPACITY)) begin
                        pl_we    = i_cmd.execute;
                        pl_waddr = new_key_m1[ADDR_W-1:0];
                        n_occ[new_key_m1[ADDR_W-1:0]] = 1'b1;
                    end
                end
            end
            FUNC_LOOKUP: begin
                if (key_ok) begin
                    n_res.status         = ST_OK;
                    n_res.out_file_ident = pl_rdata.file_ident;
                    n_res.out_row        = pl_rdata.line_row;
                    n_res.out_col        = pl_rdata.line_col;
                end
            end
            FUNC_DELETE: begin
                if (key_ok) begin
                    n_res.status = ST_OK;
                    n_occ[key_m1[ADDR_W-1:0]] = 1'b0;
                    if ({1'b0, r_req.req_key} == {1'b0, KEY_W'(r_hwm)}) begin
                        n_hwm = r_hwm - CNT_W'(1);
                    end else if (r_fsc < CNT_W'(CAPACITY)) begin
                        stk_we = i_cmd.execute;
                        n_fsc  = r_fsc + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_res.status = ST_MISSING;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_fsc   <= '0;
            r_hwm   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_occ <= n_occ;
                r_fsc <= n_fsc;
                r_hwm <= n_hwm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.execute) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/slot_key_allocator_table.sv
// top level of the slot key allocator table
// depends on skat_pkg, skat_ctrl, skat_dp (which holds two skat_ram instances)

// a request word is taken when start is high and busy is low. each word
// passes through the accept cycle, in which the payload ram and the
// free-key stack ram are read, and then the execute cycle, in which the
// operation is decided and the tables and counters are updated; busy is
// high during the execute cycle, so no new word is accepted until that word
// is through. the result word shows on o_res, marked by o_valid, high for
// a single cycle, the cycle after execute; it cannot be held off, so the
// receiver must take it then. a new word may be accepted in that same cycle.
// the table needs no clearing pass: occupancy bits reset at once.

module slot_key_allocator_table import skat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    // request side
    input  logic start,
    output logic busy,
    input  t_req i_req,
    // result side
    output logic o_valid,
    output t_res o_res
);

    // command bundle from controller to datapath
    t_cmd cmd;

    // sequencing: idle -> execute -> idle
    skat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // storage, allocation logic and the result register
    skat_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
